// File: hw/rtl/blocking_mailbox_fifo_core_macros.svh
// Assertion shorthands for the mailbox FIFO checker.
// Both sample on the rising edge of clk and are off while rst is high.
`ifndef BLOCKING_MAILBOX_FIFO_CORE_MACROS_SVH
`define BLOCKING_MAILBOX_FIFO_CORE_MACROS_SVH

// Same-cycle implication.
`define MBF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbf_pkg;

  // default sizes
  localparam int QUEUE_DEPTH_DEF  = 64;
  localparam int READER_DEPTH_DEF = 16;
  localparam int MAX_BATCH_DEF    = 64;

  // field widths
  localparam int CMD_W  = 3;
  localparam int MAIL_W = 64;
  localparam int LIM_W  = 7;
  localparam int TAG_W  = 8;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 32;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 112;

  // commands
  localparam logic [CMD_W-1:0] CMD_POST  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TRY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WAIT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_BATCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TERM  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_COUNT = 3'd5;

  // result status
  localparam logic [STAT_W-1:0] ST_MAIL  = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY = 3'd1;
  localparam logic [STAT_W-1:0] ST_QFULL = 3'd2;
  localparam logic [STAT_W-1:0] ST_RFULL = 3'd3;
  localparam logic [STAT_W-1:0] ST_COUNT = 3'd4;

  // output register source select
  localparam logic [1:0] OUT_MAIL_POP  = 2'd0;  // popped mail to requester
  localparam logic [1:0] OUT_MAIL_HAND = 2'd1;  // posted mail to parked reader
  localparam logic [1:0] OUT_RELEASE   = 2'd2;  // parked reader released empty
  localparam logic [1:0] OUT_PLAIN     = 2'd3;  // status only, to requester

  typedef struct packed {
    logic              latch;
    logic              push_mail;
    logic              pop_mail;
    logic              push_reader;
    logic              park_batch;
    logic              pop_reader;
    logic              clear_queue;
    logic              clear_head;
    logic              load_out;
    logic [1:0]        out_kind;
    logic [STAT_W-1:0] out_status;
    logic              out_inc;
    logic              out_last;
  } mbf_cmd_t;

  typedef struct packed {
    logic mail_empty;
    logic mail_full;
    logic readers_empty;
    logic readers_full;
    logic terminating;
    logic batch_done;
    logic out_free;
  } mbf_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/blocking_mailbox_fifo_core.sv
// Mailbox FIFO of 64-bit mails with a queue of parked readers. Each input item
// is one command (post, try, wait, batch wait, terminate, read dispatch count)
// and causes zero or more result items; the final one carries tlast. A post
// with nothing parked and room in the queue produces nothing. A command with
// a single result is accepted, then loads the output register once it is
// free. A batch wait reads and delivers one mail at a time, and terminate
// reads and releases one parked reader at a time, because every pop goes
// through the registered read port of the mail or reader store before the
// output register is loaded. Input is taken only while the controller is
// idle; the output register lets the next item in while a result still
// waits downstream. The mail and reader stores are not cleared at reset and
// need no clearing pass: an entry is read only after it was written. Parked
// readers are served oldest first. A batch reader woken by a post gets that
// one mail only.
`timescale 1ns / 1ps
`default_nettype none

module blocking_mailbox_fifo_core import mbf_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,   // mails, 2..4096
  parameter int READER_DEPTH = READER_DEPTH_DEF,  // parked readers, 1..64
  parameter int MAX_BATCH    = MAX_BATCH_DEF      // batch limit cap, 1..64
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // command item in
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // [63:0] mail_value, [70:64] batch_limit, [78:71] requester_id, [79] zero
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [2:0] command
  input  wire logic [CMD_W-1:0]       s_axis_tuser,
  // result item out
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // [7:0] requester_id_res, [71:8] mail_value_res, [78:72] batch_count,
  // [110:79] dispatch_count, [111] zero
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
  // [2:0] status
  output logic [STAT_W-1:0]           m_axis_tuser,
  // is_last
  output logic                        m_axis_tlast
);

  mbf_cmd_t  cmd;
  mbf_stat_t stat;

  logic [TAG_W-1:0]  out_tag;
  logic [MAIL_W-1:0] out_mail;
  logic [LIM_W-1:0]  out_bc;
  logic [CNT_W-1:0]  out_dc;

  mbf_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_command (s_axis_tuser),
    .in_ready   (s_axis_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mbf_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .READER_DEPTH (READER_DEPTH),
    .MAX_BATCH    (MAX_BATCH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_mail    (s_axis_tdata[63:0]),
    .in_lim     (s_axis_tdata[70:64]),
    .in_tag     (s_axis_tdata[78:71]),
    .out_ready  (m_axis_tready),
    .out_valid  (m_axis_tvalid),
    .out_tag    (out_tag),
    .out_status (m_axis_tuser),
    .out_mail   (out_mail),
    .out_bc     (out_bc),
    .out_dc     (out_dc),
    .out_last   (m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, out_dc, out_bc, out_mail, out_tag};

endmodule

`default_nettype wire

// File: hw/rtl/mbf_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module mbf_ctrl import mbf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [CMD_W-1:0] in_command,
  output logic                  in_ready,
  input  wire mbf_stat_t        stat,
  output mbf_cmd_t              cmd
);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_EMIT       = 3'd1;
  localparam logic [2:0] S_BATCH_EMIT = 3'd2;
  localparam logic [2:0] S_BATCH_RD   = 3'd3;
  localparam logic [2:0] S_TERM_RD    = 3'd4;
  localparam logic [2:0] S_TERM_EMIT  = 3'd5;

  logic [2:0]        state, state_next;
  logic [1:0]        pend_kind, pend_kind_next;
  logic [STAT_W-1:0] pend_status, pend_status_next;
  logic              pend_inc, pend_inc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_kind   <= pend_kind_next;
    pend_status <= pend_status_next;
    pend_inc    <= pend_inc_next;
  end

  always_comb begin
    cmd              = '0;
    state_next       = state;
    pend_kind_next   = pend_kind;
    pend_status_next = pend_status;
    pend_inc_next    = pend_inc;
    in_ready         = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch        = 1'b1;
          pend_kind_next   = OUT_PLAIN;
          pend_inc_next    = 1'b0;
          case (in_command)
            CMD_POST: begin
              if (!stat.readers_empty) begin
                cmd.pop_reader = 1'b1;
                pend_kind_next = OUT_MAIL_HAND;
                state_next     = S_EMIT;
              end else if (!stat.mail_full) begin
                cmd.push_mail = 1'b1;
              end else begin
                pend_status_next = ST_QFULL;
                state_next       = S_EMIT;
              end
            end
            CMD_TRY: begin
              if (!stat.mail_empty) begin
                cmd.pop_mail   = 1'b1;
                pend_kind_next = OUT_MAIL_POP;
              end else begin
                pend_status_next = ST_EMPTY;
              end
              state_next = S_EMIT;
            end
            CMD_WAIT: begin
              if (!stat.mail_empty) begin
                cmd.pop_mail   = 1'b1;
                pend_kind_next = OUT_MAIL_POP;
                state_next     = S_EMIT;
              end else if (stat.terminating) begin
                pend_status_next = ST_EMPTY;
                pend_inc_next    = 1'b1;   // empty single wait still counts
                state_next       = S_EMIT;
              end else if (!stat.readers_full) begin
                cmd.push_reader = 1'b1;
              end else begin
                pend_status_next = ST_RFULL;
                state_next       = S_EMIT;
              end
            end
            CMD_BATCH: begin
              if (!stat.mail_empty) begin
                cmd.pop_mail = 1'b1;
                state_next   = S_BATCH_EMIT;
              end else if (stat.terminating) begin
                pend_status_next = ST_EMPTY;
                state_next       = S_EMIT;
              end else if (!stat.readers_full) begin
                cmd.push_reader = 1'b1;
                cmd.park_batch  = 1'b1;
              end else begin
                pend_status_next = ST_RFULL;
                state_next       = S_EMIT;
              end
            end
            CMD_TERM: begin
              cmd.clear_queue = 1'b1;
              if (stat.readers_empty) begin
                cmd.clear_head = 1'b1;
              end else begin
                state_next = S_TERM_RD;
              end
            end
            CMD_COUNT: begin
              pend_status_next = ST_COUNT;
              state_next       = S_EMIT;
            end
            default: begin
              // unused codes: dropped
            end
          endcase
        end
      end

      S_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out   = 1'b1;
          cmd.out_kind   = pend_kind;
          cmd.out_status = pend_status;
          cmd.out_inc    = pend_inc;
          cmd.out_last   = 1'b1;
          state_next     = S_IDLE;
        end
      end

      S_BATCH_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = OUT_MAIL_POP;
          cmd.out_last = stat.mail_empty || stat.batch_done;
          state_next   = cmd.out_last ? S_IDLE : S_BATCH_RD;
        end
      end

      S_BATCH_RD: begin
        cmd.pop_mail = 1'b1;
        state_next   = S_BATCH_EMIT;
      end

      S_TERM_RD: begin
        cmd.pop_reader = 1'b1;
        state_next     = S_TERM_EMIT;
      end

      S_TERM_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          cmd.out_kind = OUT_RELEASE;
          cmd.out_last = stat.readers_empty;
          if (stat.readers_empty) begin
            cmd.clear_head = 1'b1;
            state_next     = S_IDLE;
          end else begin
            state_next = S_TERM_RD;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbf_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module mbf_dp import mbf_pkg::*; #(
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
  parameter int READER_DEPTH = READER_DEPTH_DEF,
  parameter int MAX_BATCH    = MAX_BATCH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mbf_cmd_t          cmd,
  output mbf_stat_t              stat,
  input  wire logic [MAIL_W-1:0] in_mail,
  input  wire logic [LIM_W-1:0]  in_lim,
  input  wire logic [TAG_W-1:0]  in_tag,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [TAG_W-1:0]       out_tag,
  output logic [STAT_W-1:0]      out_status,
  output logic [MAIL_W-1:0]      out_mail,
  output logic [LIM_W-1:0]       out_bc,
  output logic [CNT_W-1:0]       out_dc,
  output logic                   out_last
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int RPW = (READER_DEPTH > 1) ? $clog2(READER_DEPTH) : 1;
  localparam int RCW = $clog2(READER_DEPTH + 1);

  localparam logic [QPW-1:0]   QP_LAST  = QPW'(QUEUE_DEPTH - 1);
  localparam logic [QCW-1:0]   QC_FULL  = QCW'(QUEUE_DEPTH);
  localparam logic [RPW-1:0]   RP_LAST  = RPW'(READER_DEPTH - 1);
  localparam logic [RCW-1:0]   RC_FULL  = RCW'(READER_DEPTH);
  localparam logic [RCW:0]     RC_DEPTH = (RCW + 1)'(READER_DEPTH);
  localparam logic [LIM_W-1:0] LIM_MAX  = LIM_W'(MAX_BATCH);

  // latched item
  logic [MAIL_W-1:0] mail_q;
  logic [LIM_W-1:0]  lim_q;
  logic [TAG_W-1:0]  tag_q;
  logic [LIM_W-1:0]  n;

  // mail ring
  logic [MAIL_W-1:0] mail_mem [QUEUE_DEPTH];
  logic [MAIL_W-1:0] mail_rd;
  logic [QPW-1:0]    rd_ptr, wr_ptr;
  logic [QCW-1:0]    mail_count;
  logic              terminating;

  // parked reader ring
  logic [TAG_W-1:0]  rtag_mem [READER_DEPTH];
  logic [LIM_W-1:0]  rlim_mem [READER_DEPTH];
  logic [TAG_W-1:0]  rtag_rd;
  logic [LIM_W-1:0]  rlim_rd;
  logic [RPW-1:0]    rhead;
  logic [RCW-1:0]    rcount;

  logic [CNT_W-1:0]  dcount;

  logic [LIM_W-1:0]  lim_sat;
  logic [RCW:0]      tail_sum;
  logic [RPW-1:0]    tail_idx;

  logic [TAG_W-1:0]  sel_tag;
  logic [STAT_W-1:0] sel_status;
  logic [MAIL_W-1:0] sel_mail;
  logic [LIM_W-1:0]  sel_bc;
  logic              sel_inc;
  logic [CNT_W-1:0]  dc_next;

  always_comb begin
    if (in_lim == '0) begin
      lim_sat = LIM_W'(1);
    end else if (in_lim > LIM_MAX) begin
      lim_sat = LIM_MAX;
    end else begin
      lim_sat = in_lim;
    end
  end

  // tail = (head + count) mod depth; sum stays below twice the depth
  assign tail_sum = (RCW + 1)'(rhead) + (RCW + 1)'(rcount);
  assign tail_idx = (tail_sum >= RC_DEPTH) ? RPW'(tail_sum - RC_DEPTH) : RPW'(tail_sum);

  assign stat.mail_empty    = (mail_count == '0);
  assign stat.mail_full     = (mail_count == QC_FULL);
  assign stat.readers_empty = (rcount == '0);
  assign stat.readers_full  = (rcount == RC_FULL);
  assign stat.terminating   = terminating;
  assign stat.batch_done    = (n == lim_q);
  assign stat.out_free      = !out_valid || out_ready;

  always_comb begin
    unique case (cmd.out_kind)
      OUT_MAIL_POP: begin
        sel_tag    = tag_q;
        sel_status = ST_MAIL;
        sel_mail   = mail_rd;
        sel_bc     = n;
        sel_inc    = 1'b1;
      end
      OUT_MAIL_HAND: begin
        sel_tag    = rtag_rd;
        sel_status = ST_MAIL;
        sel_mail   = mail_q;
        sel_bc     = LIM_W'(1);
        sel_inc    = 1'b1;
      end
      OUT_RELEASE: begin
        sel_tag    = rtag_rd;
        sel_status = ST_EMPTY;
        sel_mail   = '0;
        sel_bc     = '0;
        sel_inc    = (rlim_rd == '0);  // single waits count when released
      end
      OUT_PLAIN: begin
        sel_tag    = tag_q;
        sel_status = cmd.out_status;
        sel_mail   = '0;
        sel_bc     = '0;
        sel_inc    = cmd.out_inc;
      end
    endcase
  end

  assign dc_next = dcount + CNT_W'(sel_inc);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      mail_count  <= '0;
      terminating <= 1'b0;
      rhead       <= '0;
      rcount      <= '0;
      dcount      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clear_queue) begin
        rd_ptr      <= '0;
        wr_ptr      <= '0;
        mail_count  <= '0;
        terminating <= 1'b1;
      end else if (cmd.push_mail) begin
        wr_ptr     <= (wr_ptr == QP_LAST) ? '0 : wr_ptr + QPW'(1);
        mail_count <= mail_count + QCW'(1);
      end else if (cmd.pop_mail) begin
        rd_ptr     <= (rd_ptr == QP_LAST) ? '0 : rd_ptr + QPW'(1);
        mail_count <= mail_count - QCW'(1);
      end

      if (cmd.clear_head) begin
        rhead <= '0;
      end else if (cmd.pop_reader) begin
        rhead  <= (rhead == RP_LAST) ? '0 : rhead + RPW'(1);
        rcount <= rcount - RCW'(1);
      end else if (cmd.push_reader) begin
        rcount <= rcount + RCW'(1);
      end

      if (cmd.load_out) begin
        dcount    <= dc_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      mail_q <= in_mail;
      lim_q  <= lim_sat;
      tag_q  <= in_tag;
      n      <= LIM_W'(cmd.pop_mail);
    end else if (cmd.pop_mail) begin
      n <= n + LIM_W'(1);
    end

    if (cmd.load_out) begin
      out_tag    <= sel_tag;
      out_status <= sel_status;
      out_mail   <= sel_mail;
      out_bc     <= sel_bc;
      out_dc     <= dc_next;
      out_last   <= cmd.out_last;
    end
  end

  // mail store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.push_mail) begin
      mail_mem[wr_ptr] <= in_mail;
    end
    if (cmd.pop_mail) begin
      mail_rd <= mail_mem[rd_ptr];
    end
  end

  // reader store
  always_ff @(posedge clk) begin
    if (cmd.push_reader) begin
      rtag_mem[tail_idx] <= in_tag;
      rlim_mem[tail_idx] <= cmd.park_batch ? lim_sat : '0;
    end
    if (cmd.pop_reader) begin
      rtag_rd <= rtag_mem[rhead];
      rlim_rd <= rlim_mem[rhead];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/mbf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "blocking_mailbox_fifo_core_macros.svh"

module mbf_checker import mbf_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   s_axis_tvalid,
  input wire logic                   s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input wire logic [CMD_W-1:0]       s_axis_tuser,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [STAT_W-1:0]      m_axis_tuser,
  input wire logic                   m_axis_tlast
);

  // a try always has a result to send, so input must close behind it
  `MBF_ASSERT_NEXT(a_try_blocks, s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TRY, !s_axis_tready, "input open right after try")

  // count read: no mail, no batch count, single result
  `MBF_ASSERT_IMP(a_count_shape, m_axis_tvalid && m_axis_tuser == ST_COUNT, m_axis_tdata[71:8] == '0 && m_axis_tdata[78:72] == '0 && m_axis_tlast, "bad count result")

  // batch count is nonzero exactly on delivered mails
  `MBF_ASSERT_IMP(a_bc_status, m_axis_tvalid, (m_axis_tuser == ST_MAIL) == (m_axis_tdata[78:72] != '0), "batch count and status disagree")

  // stalled result holds
  `MBF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

endmodule

bind blocking_mailbox_fifo_core mbf_checker u_mbf_checker (.*);

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import mbf_pkg::*;

  localparam int ITEMS     = 470;
  localparam int QUIET_TAIL = 60;    // last items run with no idling on either side
  localparam int WATCHDOG  = 2000;   // cycles with no handshake on either side
  localparam int SETTLE    = 20;     // cycles after the last result

  // command codes the block ignores
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [STAT_W-1:0] status;
    logic [MAIL_W-1:0] mail;
    logic [LIM_W-1:0]  batch_n;
    logic [CNT_W-1:0]  dispatch;
    logic              last;
  } reply_t;

  // Mailbox predictor plus the queue of replies still owed by the block.
  class mailbox_board;
    logic [MAIL_W-1:0] mails[QUEUE_DEPTH_DEF];
    int unsigned       rd_ptr, wr_ptr, mail_n;
    bit                closing;
    logic [CNT_W-1:0]  dispatched = '0;
    logic [TAG_W-1:0]  reader_tag[READER_DEPTH_DEF];
    logic [LIM_W-1:0]  reader_lim[READER_DEPTH_DEF];
    int unsigned       reader_head, reader_n;
    reply_t            due[$];
    int                errors;

    function void owe(logic [TAG_W-1:0] tag, logic [STAT_W-1:0] status,
                      logic [MAIL_W-1:0] mail, logic [LIM_W-1:0] batch_n);
      reply_t r;
      r.tag = tag;
      r.status = status;
      r.mail = mail;
      r.batch_n = batch_n;
      r.dispatch = dispatched;
      r.last = 1'b0;
      due.push_back(r);
    endfunction

    function logic [MAIL_W-1:0] pop_mail();
      logic [MAIL_W-1:0] v;
      v = mails[rd_ptr];
      rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH_DEF;
      mail_n--;
      dispatched++;
      return v;
    endfunction

    function bit park(logic [TAG_W-1:0] tag, logic [LIM_W-1:0] lim);
      int unsigned slot;
      if (reader_n >= READER_DEPTH_DEF) return 1'b0;
      slot = (reader_head + reader_n) % READER_DEPTH_DEF;
      reader_tag[slot] = tag;
      reader_lim[slot] = lim;
      reader_n++;
      return 1'b1;
    endfunction

    // Called on every accepted command item.
    function void take_command(logic [CMD_W-1:0] cmd, logic [MAIL_W-1:0] mail,
                               logic [LIM_W-1:0] lim_raw, logic [TAG_W-1:0] tag);
      int unsigned lim, first, cnt;
      reply_t r;
      lim = lim_raw;
      if (lim < 1) lim = 1;
      if (lim > MAX_BATCH_DEF) lim = MAX_BATCH_DEF;
      first = due.size();
      case (cmd)
        CMD_POST: begin
          if (reader_n > 0) begin
            // oldest parked reader takes this mail, batch readers included
            dispatched++;
            owe(reader_tag[reader_head], ST_MAIL, mail, 7'd1);
            reader_head = (reader_head + 1) % READER_DEPTH_DEF;
            reader_n--;
          end else if (mail_n < QUEUE_DEPTH_DEF) begin
            mails[wr_ptr] = mail;
            wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH_DEF;
            mail_n++;
          end else begin
            owe(tag, ST_QFULL, '0, '0);
          end
        end
        CMD_TRY: begin
          if (mail_n > 0) owe(tag, ST_MAIL, pop_mail(), 7'd1);
          else owe(tag, ST_EMPTY, '0, '0);
        end
        CMD_WAIT: begin
          if (mail_n > 0) begin
            owe(tag, ST_MAIL, pop_mail(), 7'd1);
          end else if (closing) begin
            dispatched++;
            owe(tag, ST_EMPTY, '0, '0);
          end else if (!park(tag, '0)) begin
            owe(tag, ST_RFULL, '0, '0);
          end
        end
        CMD_BATCH: begin
          if (mail_n > 0) begin
            cnt = 0;
            while (mail_n > 0 && cnt < lim) begin
              cnt++;
              owe(tag, ST_MAIL, pop_mail(), LIM_W'(cnt));
            end
          end else if (closing) begin
            owe(tag, ST_EMPTY, '0, '0);
          end else if (!park(tag, LIM_W'(lim))) begin
            owe(tag, ST_RFULL, '0, '0);
          end
        end
        CMD_TERM: begin
          mail_n = 0;
          rd_ptr = 0;
          wr_ptr = 0;
          closing = 1'b1;
          while (reader_n > 0) begin
            // a released single wait counts as a dispatch, a batch wait does not
            if (reader_lim[reader_head] == '0) dispatched++;
            owe(reader_tag[reader_head], ST_EMPTY, '0, '0);
            reader_head = (reader_head + 1) % READER_DEPTH_DEF;
            reader_n--;
          end
          reader_head = 0;
        end
        CMD_COUNT: owe(tag, ST_COUNT, '0, '0);
        default: ;
      endcase
      if (due.size() > first) begin
        r = due.pop_back();
        r.last = 1'b1;
        due.push_back(r);
      end
    endfunction

    function void field(string what, logic [MAIL_W-1:0] want, logic [MAIL_W-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, expected nothing, actual tag %0h status %0d",
                 $time, got.tag, got.status);
        return;
      end
      want = due.pop_front();
      field("requester_id", want.tag, got.tag);
      field("status", want.status, got.status);
      field("mail", want.mail, got.mail);
      field("batch_count", want.batch_n, got.batch_n);
      field("dispatch_count", want.dispatch, got.dispatch);
      field("last", want.last, got.last);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_valid = 1'b0;
  logic                   s_ready;
  logic [IN_TDATA_W-1:0]  s_data = '0;
  logic [CMD_W-1:0]       s_cmd = CMD_COUNT;
  logic                   m_valid;
  logic                   m_ready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_data;
  logic [STAT_W-1:0]      m_status;
  logic                   m_last;

  mailbox_board board;
  bit  quiet = 1'b0;        // no idling once set
  int  sent = 0;            // accepted items, ignored codes excluded
  int  idle_cycles = 0;
  int  stall_left = 0;

  blocking_mailbox_fifo_core DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_ready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_cmd),
    .m_axis_tvalid(m_valid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_data),
    .m_axis_tuser (m_status),
    .m_axis_tlast (m_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check every accepted item, stall in random bursts.
  always @(posedge clk) begin
    reply_t got;
    if (m_valid && m_ready) begin
      got.tag = m_data[7:0];
      got.mail = m_data[71:8];
      got.batch_n = m_data[78:72];
      got.dispatch = m_data[110:79];
      got.status = m_status;
      got.last = m_last;
      board.check_reply(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      m_ready <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Watchdog: no handshake on either side for too long.
  always @(posedge clk) begin
    if (rst || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic logic [MAIL_W-1:0] rand_mail();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [TAG_W-1:0] rand_tag();
    return TAG_W'($urandom_range(0, 255));
  endfunction

  // mostly short batches, sometimes the cap, sometimes anything the field holds
  function automatic logic [LIM_W-1:0] rand_lim();
    case ($urandom_range(0, 5))
      0: return LIM_W'($urandom_range(0, 127));
      1: return LIM_W'(MAX_BATCH_DEF);
      default: return LIM_W'($urandom_range(1, 8));
    endcase
  endfunction

  // Present one command item, with an optional random gap first.
  task automatic send(logic [CMD_W-1:0] cmd, logic [MAIL_W-1:0] mail,
                      logic [LIM_W-1:0] lim, logic [TAG_W-1:0] tag);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {1'b0, tag, lim, mail};
    s_cmd <= cmd;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    board.take_command(cmd, mail, lim, tag);
    if (cmd <= CMD_COUNT) sent++;
  endtask

  // Hold the sender off until every owed result has come back.
  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk); while (board.due.size() != 0);
  endtask

  initial begin
    int k;
    board = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every command but terminate, parking and wake-up
    send(CMD_COUNT, '0, 7'd1, 8'h00);
    send(CMD_TRY, '1, 7'd1, 8'hFF);                 // empty try
    send(CMD_POST, '1, 7'd127, 8'h01);
    send(CMD_POST, '0, 7'd0, 8'h02);
    send(CMD_WAIT, '0, 7'd1, 8'h03);
    send(CMD_BATCH, '0, 7'd0, 8'h04);               // limit 0 saturates to 1
    send(CMD_WAIT, '0, 7'd1, 8'hFF);                // parks
    send(CMD_BATCH, '1, 7'd127, 8'h55);             // parks, limit clipped
    send(CMD_POST, 64'h8000_0000_0000_0001, 7'd1, 8'h10);
    send(CMD_POST, 64'h7FFF_FFFF_FFFF_FFFE, 7'd1, 8'h11);  // batch reader gets one
    send(CMD_POST, 64'hAAAA_AAAA_AAAA_AAAA, 7'd1, 8'h12);
    send(CMD_POST, 64'h5555_5555_5555_5555, 7'd1, 8'h13);
    send(CMD_POST, 64'h0123_4567_89AB_CDEF, 7'd1, 8'h14);
    send(CMD_BATCH, '0, 7'd2, 8'hAA);
    send(CMD_BATCH, '0, 7'd64, 8'h80);
    send(CMD_SPARE6, '1, 7'd127, 8'hFF);
    send(CMD_SPARE7, '0, 7'd0, 8'h00);
    send(CMD_COUNT, '1, 7'd64, 8'h7F);
    drain();

    while (sent < ITEMS) begin
      if (sent >= ITEMS - QUIET_TAIL) quiet <= 1'b1;
      case ($urandom_range(0, 9))
        0, 1: begin
          // fill, sometimes past full
          if ($urandom_range(0, 3) == 0)
            k = QUEUE_DEPTH_DEF - int'(board.mail_n) + $urandom_range(1, 3);
          else
            k = $urandom_range(1, 12);
          repeat (k) send(CMD_POST, rand_mail(), rand_lim(), rand_tag());
        end
        2, 3: begin
          repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 2))
              0: send(CMD_TRY, rand_mail(), rand_lim(), rand_tag());
              1: send(CMD_WAIT, rand_mail(), rand_lim(), rand_tag());
              default: send(CMD_BATCH, rand_mail(), rand_lim(), rand_tag());
            endcase
          end
        end
        4, 5: begin
          // empty the queue, park readers (sometimes past full), wake some
          while (board.mail_n != 0) send(CMD_BATCH, rand_mail(), 7'd64, rand_tag());
          if ($urandom_range(0, 2) == 0)
            k = READER_DEPTH_DEF - int'(board.reader_n) + $urandom_range(1, 2);
          else
            k = $urandom_range(1, 6);
          repeat (k)
            send($urandom_range(0, 1) ? CMD_WAIT : CMD_BATCH, rand_mail(), rand_lim(),
                 rand_tag());
          repeat ($urandom_range(0, k)) send(CMD_POST, rand_mail(), rand_lim(), rand_tag());
        end
        6: begin
          // terminate is sticky, so this case sends it only in the second half
          if (sent < ITEMS / 2) send(CMD_COUNT, rand_mail(), rand_lim(), rand_tag());
          else send(CMD_TERM, rand_mail(), rand_lim(), rand_tag());
        end
        7: begin
          repeat ($urandom_range(1, 4))
            send(CMD_W'($urandom_range(0, 7)), rand_mail(), LIM_W'($urandom_range(0, 127)),
                 rand_tag());
        end
        8: drain();
        default: send(CMD_COUNT, rand_mail(), rand_lim(), rand_tag());
      endcase
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mbf_pkg.sv
hw/rtl/mbf_ctrl.sv
hw/rtl/mbf_dp.sv
hw/rtl/blocking_mailbox_fifo_core.sv
hw/rtl/mbf_checker.sv
bench/tb.sv
